// File: hw/rtl/rssd_pkg.sv
// rssd_pkg: shared codes for the run-length sprite stream decoder
// marker kinds, status codes, register indexes and address unit ops
// no dependencies
package rssd_pkg;

  // marker kinds in bits 7..5 of a marker byte
  localparam logic [2:0] KIND_STREAM = 3'd0;
  localparam logic [2:0] KIND_EOL    = 3'd1;
  localparam logic [2:0] KIND_REPEAT = 3'd2;
  localparam logic [2:0] KIND_SKIP   = 3'd4;

  // final status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_WIDE   = 3'd1;
  localparam logic [2:0] ST_LINES  = 3'd2;
  localparam logic [2:0] ST_MARKER = 3'd3;
  localparam logic [2:0] ST_CUT    = 3'd4;
  localparam logic [2:0] ST_SHORT  = 3'd5;
  localparam logic [2:0] ST_STRIDE = 3'd6;

  // byte phase
  localparam logic [1:0] PH_MARKER = 2'd0;
  localparam logic [1:0] PH_STREAM = 2'd1;
  localparam logic [1:0] PH_REPEAT = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_COLOR_MODE   = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [2:0] REG_FRAME_STRIDE = 3'd3;
  localparam logic [2:0] REG_ORIGIN_X     = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd5;

  // shared address adder operations
  localparam logic [2:0] ALU_ORIGIN = 3'd0;
  localparam logic [2:0] ALU_PAD    = 3'd1;
  localparam logic [2:0] ALU_LINE   = 3'd2;
  localparam logic [2:0] ALU_SKIP   = 3'd3;
  localparam logic [2:0] ALU_STEP   = 3'd4;

  localparam logic [15:0] INDEXED_FILL = 16'hFF00;

endpackage

// File: hw/rtl/rssd_code_if.sv
// rssd_code_if: input channel carrying encoded stream bytes
// no dependencies
interface rssd_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       final_byte;

  modport source (output valid, output code_byte, output final_byte, input ready);
  modport sink (input valid, input code_byte, input final_byte, output ready);
endinterface

// File: hw/rtl/rssd_result_if.sv
// rssd_result_if: output channel carrying pixel writes and final status
// no dependencies
interface rssd_result_if #(
  parameter int ADDRESS_BITS = 24
);
  logic                    valid;
  logic                    ready;
  logic                    is_status;
  logic [ADDRESS_BITS-1:0] write_address;
  logic [15:0]             pixel_value;
  logic [2:0]              status_code;
  logic                    run_last;

  modport source (output valid, output is_status, output write_address, output pixel_value,
                  output status_code, output run_last, input ready);
  modport sink (input valid, input is_status, input write_address, input pixel_value,
                input status_code, input run_last, output ready);
endinterface

// File: hw/rtl/rssd_cfg_if.sv
// rssd_cfg_if: configuration write channel
// no dependencies
interface rssd_cfg_if #(
  parameter int DIMENSION_BITS = 12
);
  logic                      valid;
  logic                      ready;
  logic [2:0]                reg_index;
  logic [DIMENSION_BITS-1:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

// File: hw/rtl/rssd_cfg_regs.sv
// rssd_cfg_regs: configuration register file of the decoder
// depends on rssd_pkg and rssd_cfg_if
module rssd_cfg_regs
  import rssd_pkg::*;
#(
  parameter int DIMENSION_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  rssd_cfg_if.sink                  cfg,
  output logic                      color_mode,
  output logic [DIMENSION_BITS-1:0] image_width,
  output logic [DIMENSION_BITS-1:0] image_height,
  output logic [DIMENSION_BITS-1:0] frame_stride,
  output logic [DIMENSION_BITS-1:0] origin_x,
  output logic [DIMENSION_BITS-1:0] origin_y
);

  assign cfg.ready = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= 1'b0;
      image_width  <= DIMENSION_BITS'(1);
      image_height <= DIMENSION_BITS'(1);
      frame_stride <= DIMENSION_BITS'(1);
      origin_x     <= '0;
      origin_y     <= '0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_COLOR_MODE:   color_mode   <= cfg.data[0];
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        REG_FRAME_STRIDE: frame_stride <= cfg.data;
        REG_ORIGIN_X:     origin_x     <= cfg.data;
        REG_ORIGIN_Y:     origin_y     <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/rssd_addr_alu.sv
// rssd_addr_alu: shared address adder with operand selection
// depends on rssd_pkg
module rssd_addr_alu
  import rssd_pkg::*;
#(
  parameter int ADDRESS_BITS   = 24,
  parameter int DIMENSION_BITS = 12
) (
  input  logic [2:0]                  op,
  input  logic [ADDRESS_BITS-1:0]     target,
  input  logic [DIMENSION_BITS-1:0]   origin_x,
  input  logic [2*DIMENSION_BITS-1:0] prod,
  input  logic [DIMENSION_BITS-1:0]   image_width,
  input  logic [DIMENSION_BITS-1:0]   frame_stride,
  input  logic [DIMENSION_BITS:0]     column,
  input  logic [5:0]                  run_cnt,
  output logic [ADDRESS_BITS-1:0]     sum
);

  logic [DIMENSION_BITS:0]        pad_len;
  logic signed [DIMENSION_BITS:0] line_skip;
  logic [ADDRESS_BITS-1:0]        a_op;
  logic [ADDRESS_BITS-1:0]        b_op;

  // remaining pixels of a short line, and the stride gap at a line change
  assign pad_len   = {1'b0, image_width} - column;
  assign line_skip = $signed({1'b0, frame_stride}) - $signed({1'b0, image_width});

  always_comb begin
    a_op = target;
    b_op = '0;
    case (op)
      ALU_ORIGIN: begin
        a_op = ADDRESS_BITS'(origin_x);
        b_op = ADDRESS_BITS'(prod);
      end
      ALU_PAD:  b_op = ADDRESS_BITS'(pad_len);
      ALU_LINE: b_op = ADDRESS_BITS'(line_skip);
      ALU_SKIP: b_op = ADDRESS_BITS'(run_cnt);
      ALU_STEP: b_op = ADDRESS_BITS'(1);
      default:  b_op = '0;
    endcase
  end

  // address arithmetic wraps at the address width
  assign sum = a_op + b_op;

endmodule

// File: hw/rtl/rle_sprite_stream_decoder.sv
// rle_sprite_stream_decoder: top level, byte sequencer and result register
// depends on rssd_pkg, the three channel interfaces, rssd_cfg_regs, rssd_addr_alu
//
// Usage:
//   codes   - sink of encoded bytes (code_byte, final_byte), one word per byte
//   results - source of pixel writes (is_status=0) and one final status word
//             (is_status=1) per stream; run_last marks the last word of a byte
//   cfg     - register writes, always ready; write only while no byte is in flight
// Timing:
//   a byte is taken only in the idle state; a marker byte passes the decode state,
//   then the pad, line or mark states that it needs, and the final state; the first
//   byte of a stream passes a multiply and an origin add state before decode, and a
//   pixel byte passes decode, one emit step per pixel write of its run (up to 32)
//   and the final state. The status word of the final byte goes out from the final
//   state. All address updates go through one shared adder, at most one per cycle.
//   A pixel write enters the output register from the emit state of its byte.
// Stall:
//   results sit in one output register; when the receiver holds ready low the
//   sequencer waits with the next write; a new byte can be taken while the
//   last result of the previous one still waits.
// Reset:
//   rst clears the sequencer and stream state and restores the register
//   defaults; the next byte starts a new image, as after every final byte.
module rle_sprite_stream_decoder
  import rssd_pkg::*;
#(
  parameter int ADDRESS_BITS   = 24,
  parameter int DIMENSION_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  rssd_code_if.sink  codes,
  rssd_result_if.source results,
  rssd_cfg_if.sink   cfg
);

  localparam int DB = DIMENSION_BITS;
  localparam int AB = ADDRESS_BITS;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ORG   = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_PAD   = 4'd4;
  localparam logic [3:0] S_LINE  = 4'd5;
  localparam logic [3:0] S_MARK  = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic          color_mode;
  logic [DB-1:0] image_width;
  logic [DB-1:0] image_height;
  logic [DB-1:0] frame_stride;
  logic [DB-1:0] origin_x;
  logic [DB-1:0] origin_y;

  logic [3:0]      state;
  logic [7:0]      byte_r;
  logic            fin_r;
  logic            first_byte_flag;
  logic [1:0]      byte_phase;
  logic [5:0]      run_left;
  logic [5:0]      emit_left;
  logic [7:0]      pending_low_byte;
  logic            have_low;
  logic [DB:0]     column;
  logic [DB:0]     row;
  logic [AB-1:0]   target_address;
  logic [2:0]      error_latch;
  logic [15:0]     pixel;
  logic [2*DB-1:0] prod;
  logic            line_to_mark;

  logic [2:0]    alu_op;
  logic [AB-1:0] alu_sum;
  logic [2:0]    kind;
  logic [5:0]    run_cnt;
  logic [DB:0]   col_sum;
  logic [DB:0]   row_inc;
  logic [DB:0]   width_x;
  logic [DB:0]   height_x;
  logic          can_write;
  logic          out_free;
  logic          emit_step;
  logic          out_load;
  logic [2:0]    final_code;

  rssd_cfg_regs #(.DIMENSION_BITS(DB)) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .color_mode   (color_mode),
    .image_width  (image_width),
    .image_height (image_height),
    .frame_stride (frame_stride),
    .origin_x     (origin_x),
    .origin_y     (origin_y)
  );

  rssd_addr_alu #(.ADDRESS_BITS(AB), .DIMENSION_BITS(DB)) u_alu (
    .op           (alu_op),
    .target       (target_address),
    .origin_x     (origin_x),
    .prod         (prod),
    .image_width  (image_width),
    .frame_stride (frame_stride),
    .column       (column),
    .run_cnt      (run_cnt),
    .sum          (alu_sum)
  );

  // marker fields and line bookkeeping
  assign kind      = byte_r[7:5];
  assign run_cnt   = {1'b0, byte_r[4:0]} + 6'd1;
  assign col_sum   = column + (DB+1)'(run_cnt);
  assign row_inc   = row + (DB+1)'(1);
  assign width_x   = {1'b0, image_width};
  assign height_x  = {1'b0, image_height};
  assign can_write = frame_stride >= image_width;
  assign out_free  = !results.valid || results.ready;
  assign emit_step = !can_write || out_free;
  assign codes.ready = (state == S_IDLE);

  // a new word enters the output register this cycle
  assign out_load = (state == S_EMIT && emit_step && can_write) ||
                    (state == S_FIN && fin_r && out_free);

  // shared adder operation per state
  always_comb begin
    case (state)
      S_ORG:   alu_op = ALU_ORIGIN;
      S_PAD:   alu_op = ALU_PAD;
      S_LINE:  alu_op = ALU_LINE;
      S_MARK:  alu_op = ALU_SKIP;
      default: alu_op = ALU_STEP;
    endcase
  end

  // status at the end of a stream
  always_comb begin
    if (error_latch != ST_OK) final_code = error_latch;
    else if (byte_phase != PH_MARKER) final_code = ST_CUT;
    else if (row < height_x) final_code = ST_SHORT;
    else if (!can_write) final_code = ST_STRIDE;
    else final_code = ST_OK;
  end

  // byte sequencer and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      first_byte_flag  <= 1'b1;
      byte_phase       <= PH_MARKER;
      run_left         <= '0;
      emit_left        <= '0;
      pending_low_byte <= '0;
      have_low         <= 1'b0;
      column           <= '0;
      row              <= '0;
      target_address   <= '0;
      error_latch      <= ST_OK;
      line_to_mark     <= 1'b0;
      results.valid    <= 1'b0;
    end else begin
      if (results.ready && !out_load) results.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (codes.valid) begin
            byte_r <= codes.code_byte;
            fin_r  <= codes.final_byte;
            if (first_byte_flag) begin
              first_byte_flag <= 1'b0;
              state           <= S_MUL;
            end else begin
              state <= S_DEC;
            end
          end
        end
        S_MUL: begin
          prod  <= (2*DB)'(frame_stride) * (2*DB)'(origin_y);
          state <= S_ORG;
        end
        S_ORG: begin
          target_address <= alu_sum;
          state          <= S_DEC;
        end
        S_DEC: begin
          if (error_latch != ST_OK) begin
            state <= S_FIN;
          end else if (byte_phase == PH_MARKER) begin
            if (kind == KIND_EOL) begin
              // a line end at column zero after the last line is padding
              line_to_mark <= 1'b0;
              if (column == '0 && row == height_x) state <= S_FIN;
              else if (column < width_x) state <= S_PAD;
              else state <= S_LINE;
            end else if (column == width_x) begin
              // full line wraps before the next run
              line_to_mark <= 1'b1;
              state        <= S_LINE;
            end else begin
              state <= S_MARK;
            end
          end else if (color_mode) begin
            pixel     <= INDEXED_FILL | {8'h00, byte_r};
            emit_left <= (byte_phase == PH_STREAM) ? 6'd1 : run_left;
            state     <= S_EMIT;
          end else if (!have_low) begin
            pending_low_byte <= byte_r;
            have_low         <= 1'b1;
            state            <= S_FIN;
          end else begin
            pixel     <= {byte_r, pending_low_byte};
            have_low  <= 1'b0;
            emit_left <= (byte_phase == PH_STREAM) ? 6'd1 : run_left;
            state     <= S_EMIT;
          end
        end
        S_PAD: begin
          target_address <= alu_sum;
          state          <= S_LINE;
        end
        S_LINE: begin
          column         <= '0;
          row            <= row_inc;
          target_address <= alu_sum;
          if (row_inc > height_x) error_latch <= ST_LINES;
          state <= line_to_mark ? S_MARK : S_FIN;
        end
        S_MARK: begin
          state <= S_FIN;
          if (error_latch == ST_OK) begin
            if (!(kind inside {KIND_STREAM, KIND_REPEAT, KIND_SKIP})) begin
              error_latch <= ST_MARKER;
            end else begin
              column <= col_sum;
              if (col_sum > width_x) begin
                error_latch <= ST_WIDE;
              end else if (kind == KIND_SKIP) begin
                target_address <= alu_sum;
              end else begin
                run_left   <= run_cnt;
                byte_phase <= (kind == KIND_STREAM) ? PH_STREAM : PH_REPEAT;
                have_low   <= 1'b0;
              end
            end
          end
        end
        S_EMIT: begin
          if (emit_step) begin
            if (can_write) begin
              results.valid         <= 1'b1;
              results.is_status     <= 1'b0;
              results.write_address <= target_address;
              results.pixel_value   <= pixel;
              results.status_code   <= ST_OK;
              results.run_last      <= (emit_left == 6'd1) && !fin_r;
            end
            target_address <= alu_sum;
            emit_left      <= emit_left - 6'd1;
            run_left       <= run_left - 6'd1;
            if (emit_left == 6'd1) begin
              if (run_left == 6'd1) byte_phase <= PH_MARKER;
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!fin_r) begin
            state <= S_IDLE;
          end else if (out_free) begin
            results.valid         <= 1'b1;
            results.is_status     <= 1'b1;
            results.write_address <= '0;
            results.pixel_value   <= '0;
            results.status_code   <= final_code;
            results.run_last      <= 1'b1;
            // stream state back to its start, registers kept
            byte_phase       <= PH_MARKER;
            run_left         <= '0;
            pending_low_byte <= '0;
            have_low         <= 1'b0;
            column           <= '0;
            row              <= '0;
            target_address   <= '0;
            error_latch      <= ST_OK;
            first_byte_flag  <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a status word always closes its byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.is_status) |-> results.run_last)
    else $error("status word without run_last");

  // pixel writes carry no status code
  a_write_code: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.is_status) |-> (results.status_code == ST_OK))
    else $error("pixel write with nonzero status code");

  // a taken byte keeps the input closed for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (codes.valid && codes.ready) |=> !codes.ready)
    else $error("input ready right after a byte was taken");

  // an error stops all further pixel writes of the stream
  a_no_write_after_error: assert property (@(posedge clk) disable iff (rst)
    (error_latch != ST_OK && state == S_EMIT) |-> 1'b0)
    else $error("pixel run started after an error");

endmodule
